/* rtl/core/mrtu_pkg.sv */
`timescale 1ns / 1ps
// shared types, codes and the crc-16/modbus byte update for the rtu receive framer
// no dependencies

package mrtu_pkg;

    // input word kinds
    localparam logic [2:0] KIND_BYTE     = 3'd0;
    localparam logic [2:0] KIND_TICK     = 3'd1;
    localparam logic [2:0] KIND_START_RX = 3'd2;
    localparam logic [2:0] KIND_RESP     = 3'd3;
    localparam logic [2:0] KIND_TX_DONE  = 3'd4;
    localparam logic [2:0] KIND_READ     = 3'd5;

    // error codes
    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_CRC  = 2'd1;
    localparam logic [1:0] ERR_LINE = 2'd2;

    // configuration register indexes
    localparam logic REG_SILENCE  = 1'b0;
    localparam logic REG_RESPONSE = 1'b1;

    // crc constants
    localparam logic [15:0] CRC_PRESET = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [15:0] CRC_LSB    = 16'h0001;

    // register reset values
    localparam logic [15:0] SILENCE_RESET  = 16'd401;
    localparam logic [15:0] RESPONSE_RESET = 16'd10000;

    // status snapshot handed from the state logic to the output stage
    typedef struct packed {
        logic        busy;
        logic        err_flag;
        logic [1:0]  err_code;
        logic        ready;
        logic [7:0]  length;
        logic        timeout;
        logic [15:0] err_count;
        logic        drive;
    } status_t;

    // reflected crc-16 update over one byte, eight shift steps
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if ((c & CRC_LSB) != 16'h0000)
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

/* rtl/core/mrtu_ram.sv */
`timescale 1ns / 1ps
// generic simple dual-port ram, one write and one registered read port
// no dependencies

module mrtu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/mrtu_state.sv */
`timescale 1ns / 1ps
// framer state: counters, timers, crc, flags and configuration registers
// depends on mrtu_pkg

module mrtu_state #(
    parameter int FRAME_BYTES = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic                           cfg_index,
    input  logic [15:0]                    cfg_data,
    input  logic                           accept,
    input  logic [2:0]                     kind,
    input  logic [7:0]                     data_byte,
    input  logic                           line_error,
    output logic                           buf_we,
    output logic [$clog2(FRAME_BYTES)-1:0] buf_waddr,
    output mrtu_pkg::status_t              status_next
);

    localparam int AW = $clog2(FRAME_BYTES);
    localparam logic [AW-1:0] STORE_LIMIT = AW'(FRAME_BYTES - 1);

    logic [15:0]   silence_ticks_reg;
    logic [15:0]   response_ticks_reg;

    logic [AW-1:0] stored_reg,     stored_next;
    logic [15:0]   crc_reg,        crc_next;
    logic [15:0]   sil_cnt_reg,    sil_cnt_next;
    logic          sil_run_reg,    sil_run_next;
    logic [15:0]   resp_cnt_reg,   resp_cnt_next;
    logic          resp_run_reg,   resp_run_next;
    logic          timeout_reg,    timeout_next;
    logic          busy_reg,       busy_next;
    logic          err_flag_reg,   err_flag_next;
    logic [1:0]    err_code_reg,   err_code_next;
    logic          ready_reg,      ready_next;
    logic          rx_mode_reg,    rx_mode_next;
    logic          drive_reg,      drive_next;
    logic [15:0]   fail_cnt_reg,   fail_cnt_next;
    logic          we_c;
    logic [16:0]   sil_sum;
    logic [16:0]   resp_sum;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            silence_ticks_reg  <= mrtu_pkg::SILENCE_RESET;
            response_ticks_reg <= mrtu_pkg::RESPONSE_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == mrtu_pkg::REG_SILENCE)
            begin
                silence_ticks_reg <= cfg_data;
            end
            else
            begin
                response_ticks_reg <= cfg_data;
            end
        end
    end

    // next state for one input word
    always_comb
    begin
        stored_next   = stored_reg;
        crc_next      = crc_reg;
        sil_cnt_next  = sil_cnt_reg;
        sil_run_next  = sil_run_reg;
        resp_cnt_next = resp_cnt_reg;
        resp_run_next = resp_run_reg;
        timeout_next  = timeout_reg;
        busy_next     = busy_reg;
        err_flag_next = err_flag_reg;
        err_code_next = err_code_reg;
        ready_next    = ready_reg;
        rx_mode_next  = rx_mode_reg;
        drive_next    = drive_reg;
        fail_cnt_next = fail_cnt_reg;
        we_c          = 1'b0;
        sil_sum       = {1'b0, sil_cnt_reg} + 17'd1;
        resp_sum      = 17'd0;

        case (kind)
            mrtu_pkg::KIND_BYTE:
            begin
                busy_next  = 1'b1;
                ready_next = 1'b0;
                if (line_error)
                begin
                    err_code_next = mrtu_pkg::ERR_LINE;
                    err_flag_next = 1'b1;
                end
                else
                begin
                    err_code_next = mrtu_pkg::ERR_NONE;
                    err_flag_next = 1'b0;
                    if (stored_reg < STORE_LIMIT)
                    begin
                        we_c         = 1'b1;
                        stored_next  = stored_reg + AW'(1);
                        crc_next     = mrtu_pkg::crc_byte(crc_reg, data_byte);
                        sil_cnt_next = '0;
                        sil_run_next = 1'b1;
                    end
                end
            end
            mrtu_pkg::KIND_TICK:
            begin
                // silence timer goes first
                if (sil_run_reg)
                begin
                    if (sil_sum >= {1'b0, silence_ticks_reg})
                    begin
                        resp_run_next = 1'b0;
                        resp_cnt_next = '0;
                        timeout_next  = 1'b0;
                        sil_run_next  = 1'b0;
                        sil_cnt_next  = '0;
                        if (rx_mode_reg)
                        begin
                            if (crc_reg == 16'h0000)
                            begin
                                err_flag_next = 1'b0;
                                busy_next     = 1'b0;
                                ready_next    = 1'b1;
                                drive_next    = 1'b1;
                            end
                            else
                            begin
                                if (fail_cnt_reg != 16'hFFFF)
                                begin
                                    fail_cnt_next = fail_cnt_reg + 16'd1;
                                end
                                err_flag_next = 1'b1;
                                err_code_next = mrtu_pkg::ERR_CRC;
                                stored_next   = '0;
                                crc_next      = mrtu_pkg::CRC_PRESET;
                                ready_next    = 1'b0;
                                drive_next    = 1'b0;
                                rx_mode_next  = 1'b1;
                                busy_next     = 1'b0;
                            end
                        end
                        else
                        begin
                            busy_next = 1'b0;
                        end
                    end
                    else
                    begin
                        sil_cnt_next = sil_sum[15:0];
                    end
                end
                // response timer sees the silence outcome
                if (resp_run_next)
                begin
                    resp_sum = {1'b0, resp_cnt_next} + 17'd1;
                    if (resp_sum >= {1'b0, response_ticks_reg})
                    begin
                        timeout_next  = 1'b1;
                        resp_run_next = 1'b0;
                        resp_cnt_next = '0;
                    end
                    else
                    begin
                        resp_cnt_next = resp_sum[15:0];
                    end
                end
            end
            mrtu_pkg::KIND_START_RX:
            begin
                stored_next  = '0;
                crc_next     = mrtu_pkg::CRC_PRESET;
                ready_next   = 1'b0;
                drive_next   = 1'b0;
                rx_mode_next = 1'b1;
                busy_next    = 1'b0;
            end
            mrtu_pkg::KIND_RESP:
            begin
                timeout_next  = 1'b0;
                resp_cnt_next = '0;
                resp_run_next = 1'b1;
            end
            mrtu_pkg::KIND_TX_DONE:
            begin
                rx_mode_next = 1'b0;
                drive_next   = 1'b1;
                busy_next    = 1'b1;
                sil_cnt_next = '0;
                sil_run_next = 1'b1;
            end
            default:
            begin
                // buffer reads and unused kinds leave the state alone
            end
        endcase
    end

    // state registers, updated once per accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_reg   <= '0;
            crc_reg      <= mrtu_pkg::CRC_PRESET;
            sil_cnt_reg  <= '0;
            sil_run_reg  <= 1'b0;
            resp_cnt_reg <= '0;
            resp_run_reg <= 1'b0;
            timeout_reg  <= 1'b0;
            busy_reg     <= 1'b0;
            err_flag_reg <= 1'b0;
            err_code_reg <= mrtu_pkg::ERR_NONE;
            ready_reg    <= 1'b0;
            rx_mode_reg  <= 1'b0;
            drive_reg    <= 1'b0;
            fail_cnt_reg <= '0;
        end
        else if (accept)
        begin
            stored_reg   <= stored_next;
            crc_reg      <= crc_next;
            sil_cnt_reg  <= sil_cnt_next;
            sil_run_reg  <= sil_run_next;
            resp_cnt_reg <= resp_cnt_next;
            resp_run_reg <= resp_run_next;
            timeout_reg  <= timeout_next;
            busy_reg     <= busy_next;
            err_flag_reg <= err_flag_next;
            err_code_reg <= err_code_next;
            ready_reg    <= ready_next;
            rx_mode_reg  <= rx_mode_next;
            drive_reg    <= drive_next;
            fail_cnt_reg <= fail_cnt_next;
        end
    end

    // buffer write goes to the next free slot
    assign buf_we    = accept & we_c;
    assign buf_waddr = stored_reg;

    // snapshot after the update
    always_comb
    begin
        status_next.busy      = busy_next;
        status_next.err_flag  = err_flag_next;
        status_next.err_code  = err_code_next;
        status_next.ready     = ready_next;
        status_next.length    = 8'(stored_next);
        status_next.timeout   = timeout_next;
        status_next.err_count = fail_cnt_next;
        status_next.drive     = drive_next;
    end

    // a ready frame always has the driver turned to transmit
    a_ready_drive: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg |-> drive_reg)
        else $error("frame ready without transmit drive");

    // the buffer never fills past its last usable slot
    a_stored_limit: assert property (@(posedge clk) disable iff (!rst_n)
        stored_reg <= STORE_LIMIT)
        else $error("stored count beyond buffer limit");

    // idle timers hold a cleared count
    a_sil_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !sil_run_reg |-> sil_cnt_reg == 16'h0000)
        else $error("silence count moved while stopped");

    a_resp_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !resp_run_reg |-> resp_cnt_reg == 16'h0000)
        else $error("response count moved while stopped");

    // a crc failure bumps the counter unless it is already saturated
    a_fail_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && kind == mrtu_pkg::KIND_TICK && err_code_next == mrtu_pkg::ERR_CRC
         && err_code_reg != mrtu_pkg::ERR_CRC && fail_cnt_reg != 16'hFFFF)
        |=> fail_cnt_reg == $past(fail_cnt_reg) + 16'd1)
        else $error("crc failure not counted");

endmodule

/* rtl/core/modbus_rtu_frame_receiver_core.sv */
`timescale 1ns / 1ps
// top level of the modbus rtu receive framer: input handshake, frame buffer, output word
// depends on mrtu_pkg, mrtu_state and mrtu_ram

// Usage
//   Input words carry kind, data_byte, line_error and read_address under in_valid/in_stall;
//   each one is taken at an edge with in_valid high and in_stall low. Kinds are a received
//   uart byte, a timer tick, start receive, start response wait, transmit done and a
//   buffer read. Every accepted word gives exactly one result word on out_valid/out_stall
//   with the flags, counts and driver direction after that word, plus the buffer byte for
//   a read (zero otherwise).
//   out_valid rises in the cycle after acceptance. A new word is taken every cycle unless
//   in_stall is high: the state update and crc (eight unrolled shift steps) finish in the
//   accepting cycle, and the buffer read comes back from the registered ram port together
//   with the result. The result register is the only output buffer; while out_stall holds
//   a waiting word, in_stall goes high and the ram read data is held.
//   Reset clears all flags, counters and timers, presets the crc and loads the silence
//   and response lengths with their defaults; buffer contents are not cleared and an
//   entry that was never written reads back as an arbitrary byte.
//   Registers are written through cfg_write/cfg_index/cfg_data while no word is in flight.

module modbus_rtu_frame_receiver_core #(
    parameter int FRAME_BYTES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  kind,
    input  logic [7:0]  data_byte,
    input  logic        line_error,
    input  logic [7:0]  read_address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        busy_res,
    output logic        error_flag,
    output logic [1:0]  error_code,
    output logic        frame_ready,
    output logic [7:0]  frame_length,
    output logic        response_timeout,
    output logic [15:0] error_count,
    output logic        drive_transmit,
    output logic [7:0]  read_data
);

    localparam int AW  = $clog2(FRAME_BYTES);
    localparam int AXW = ((AW > 8) ? AW : 8) + 1;

    logic                 accept;
    logic                 out_free;
    logic                 buf_we;
    logic [AW-1:0]        buf_waddr;
    logic                 rd_re;
    logic                 addr_ok;
    logic [AXW-1:0]       addr_ext;
    logic [7:0]           ram_q;
    mrtu_pkg::status_t    status_next;
    mrtu_pkg::status_t    status_reg;
    logic                 out_valid_reg;
    logic                 rd_sel_reg;

    // handshake: output register is the only buffer
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !out_free;
    assign accept   = in_valid && out_free;

    // read address range check
    assign addr_ext = AXW'(read_address);
    assign addr_ok  = addr_ext < AXW'(FRAME_BYTES);
    assign rd_re    = accept && (kind == mrtu_pkg::KIND_READ) && addr_ok;

    mrtu_state #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_state (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .kind        (kind),
        .data_byte   (data_byte),
        .line_error  (line_error),
        .buf_we      (buf_we),
        .buf_waddr   (buf_waddr),
        .status_next (status_next)
    );

    mrtu_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_BYTES)
    ) u_buf (
        .clk   (clk),
        .we    (buf_we),
        .waddr (buf_waddr),
        .wdata (data_byte),
        .re    (rd_re),
        .raddr (addr_ext[AW-1:0]),
        .rdata (ram_q)
    );

    // output word valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid;
        end
    end

    // output word payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            rd_sel_reg <= rd_re;
        end
    end

    assign out_valid        = out_valid_reg;
    assign busy_res         = status_reg.busy;
    assign error_flag       = status_reg.err_flag;
    assign error_code       = status_reg.err_code;
    assign frame_ready      = status_reg.ready;
    assign frame_length     = status_reg.length;
    assign response_timeout = status_reg.timeout;
    assign error_count      = status_reg.err_count;
    assign drive_transmit   = status_reg.drive;
    assign read_data        = rd_sel_reg ? ram_q : 8'h00;

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// self-checking bench for the modbus rtu receive framer: frames, crc, timers, buffer reads
// a behavioral copy of the framer predicts every result word; depends on mrtu_pkg and the core

module tb_top;

    localparam int FRAME_BYTES  = 256;
    localparam int HOLD_CYCLES  = 80;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int REPORT_LIMIT = 10;

    // kinds outside the command set, the framer must ignore them
    localparam logic [2:0] KIND_SPARE6 = 3'd6;
    localparam logic [2:0] KIND_SPARE7 = 3'd7;

    // one result word, ordered as the output ports
    typedef struct packed {
        logic        busy;
        logic        err_flag;
        logic [1:0]  err_code;
        logic        ready;
        logic [7:0]  length;
        logic        timeout;
        logic [15:0] err_count;
        logic        drive;
        logic [7:0]  rdata;
    } framer_status_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_write    = 1'b0;
    logic        cfg_index    = 1'b0;
    logic [15:0] cfg_data     = 16'h0000;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic [2:0]  kind         = mrtu_pkg::KIND_TICK;
    logic [7:0]  data_byte    = 8'h00;
    logic        line_error   = 1'b0;
    logic [7:0]  read_address = 8'h00;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic        busy_res;
    logic        error_flag;
    logic [1:0]  error_code;
    logic        frame_ready;
    logic [7:0]  frame_length;
    logic        response_timeout;
    logic [15:0] error_count;
    logic        drive_transmit;
    logic [7:0]  read_data;

    // framer state as the bench sees it
    logic [7:0]  frame_mem [FRAME_BYTES];
    int unsigned fill_count;
    int unsigned written_span;
    logic [15:0] crc_acc;
    int unsigned gap_count;
    logic        gap_running;
    int unsigned wait_count;
    logic        wait_running;
    logic        timeout_hit;
    logic        busy_st;
    logic        err_st;
    logic [1:0]  code_st;
    logic        ready_st;
    logic        rx_mode;
    logic        tx_drive;
    logic [15:0] fail_total;
    logic [15:0] gap_len;
    logic [15:0] wait_len;

    framer_status_t framer_status_q [$];
    framer_status_t seen_status;
    framer_status_t want_status;

    int send_gap_pct  = 0;
    int recv_gap_pct  = 0;
    int words_sent    = 0;
    int words_checked = 0;
    int fail_count    = 0;
    int cycle_count   = 0;
    int hold_req      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    modbus_rtu_frame_receiver_core #(
        .FRAME_BYTES(FRAME_BYTES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .kind(kind),
        .data_byte(data_byte),
        .line_error(line_error),
        .read_address(read_address),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .busy_res(busy_res),
        .error_flag(error_flag),
        .error_code(error_code),
        .frame_ready(frame_ready),
        .frame_length(frame_length),
        .response_timeout(response_timeout),
        .error_count(error_count),
        .drive_transmit(drive_transmit),
        .read_data(read_data)
    );

    // 50 MHz clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words checked", cycle_count, words_checked);
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side stall: random, or a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_gap_pct);
        end
    end

    // reflected crc-16 over one byte, bit at a time
    function automatic logic [15:0] modbus_crc_step(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        logic        lsb;
        r = acc ^ {8'h00, b};
        repeat (8)
        begin
            lsb = r[0];
            r = r >> 1;
            if (lsb)
            begin
                r = r ^ mrtu_pkg::CRC_POLY;
            end
        end
        return r;
    endfunction

    // clear the frame and listen again
    function automatic void restart_reception();
        fill_count = 0;
        crc_acc    = mrtu_pkg::CRC_PRESET;
        ready_st   = 1'b0;
        tx_drive   = 1'b0;
        rx_mode    = 1'b1;
        busy_st    = 1'b0;
    endfunction

    // apply one accepted word to the framer state and queue the status it leaves
    function automatic void advance_framer(input logic [2:0] k, input logic [7:0] d,
                                           input logic le, input logic [7:0] a);
        logic [7:0] rd;
        rd = 8'h00;
        case (k)
            mrtu_pkg::KIND_BYTE:
            begin
                busy_st  = 1'b1;
                ready_st = 1'b0;
                if (le)
                begin
                    code_st = mrtu_pkg::ERR_LINE;
                    err_st  = 1'b1;
                end
                else
                begin
                    code_st = mrtu_pkg::ERR_NONE;
                    err_st  = 1'b0;
                    // a full buffer drops the byte without touching crc or silence
                    if (fill_count < FRAME_BYTES - 1)
                    begin
                        frame_mem[fill_count] = d;
                        fill_count++;
                        if (fill_count > written_span)
                        begin
                            written_span = fill_count;
                        end
                        crc_acc     = modbus_crc_step(crc_acc, d);
                        gap_count   = 0;
                        gap_running = 1'b1;
                    end
                end
            end
            mrtu_pkg::KIND_TICK:
            begin
                // silence first, its expiry also cancels the response wait
                if (gap_running)
                begin
                    gap_count++;
                    if (gap_count >= gap_len)
                    begin
                        wait_running = 1'b0;
                        wait_count   = 0;
                        timeout_hit  = 1'b0;
                        gap_running  = 1'b0;
                        gap_count    = 0;
                        if (!rx_mode)
                        begin
                            busy_st = 1'b0;
                        end
                        else if (crc_acc == 16'h0000)
                        begin
                            err_st   = 1'b0;
                            busy_st  = 1'b0;
                            ready_st = 1'b1;
                            tx_drive = 1'b1;
                        end
                        else
                        begin
                            if (fail_total != 16'hFFFF)
                            begin
                                fail_total++;
                            end
                            err_st  = 1'b1;
                            code_st = mrtu_pkg::ERR_CRC;
                            restart_reception();
                        end
                    end
                end
                if (wait_running)
                begin
                    wait_count++;
                    if (wait_count >= wait_len)
                    begin
                        timeout_hit  = 1'b1;
                        wait_running = 1'b0;
                        wait_count   = 0;
                    end
                end
            end
            mrtu_pkg::KIND_START_RX:
            begin
                restart_reception();
            end
            mrtu_pkg::KIND_RESP:
            begin
                timeout_hit  = 1'b0;
                wait_count   = 0;
                wait_running = 1'b1;
            end
            mrtu_pkg::KIND_TX_DONE:
            begin
                rx_mode     = 1'b0;
                tx_drive    = 1'b1;
                busy_st     = 1'b1;
                gap_count   = 0;
                gap_running = 1'b1;
            end
            mrtu_pkg::KIND_READ:
            begin
                rd = frame_mem[a];
            end
            default:
            begin
            end
        endcase
        framer_status_q.push_back({busy_st, err_st, code_st, ready_st, fill_count[7:0],
                                   timeout_hit, fail_total, tx_drive, rd});
    endfunction

    function automatic string status_text(input framer_status_t s);
        return {$sformatf("busy=%0d err=%0d code=%0d ready=%0d len=%0d ",
                          s.busy, s.err_flag, s.err_code, s.ready, s.length),
                $sformatf("timeout=%0d count=%0d drive=%0d data=%02h",
                          s.timeout, s.err_count, s.drive, s.rdata)};
    endfunction

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen_status = {busy_res, error_flag, error_code, frame_ready, frame_length,
                           response_timeout, error_count, drive_transmit, read_data};
            if (framer_status_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                begin
                    $display("result word %0d arrived with nothing pending: %s",
                             words_checked, status_text(seen_status));
                end
            end
            else
            begin
                want_status = framer_status_q.pop_front();
                if (seen_status !== want_status)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                    begin
                        $display("result word %0d mismatch", words_checked);
                        $display("  expected %s", status_text(want_status));
                        $display("  actual   %s", status_text(seen_status));
                    end
                end
            end
            words_checked++;
        end
    end

    // offer one word, hold it until taken, then update the prediction
    task automatic send_word(input logic [2:0] k, input logic [7:0] d, input logic le,
                             input logic [7:0] a);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        kind         <= k;
        data_byte    <= d;
        line_error   <= le;
        read_address <= a;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        advance_framer(k, d, le, a);
        words_sent++;
    endtask

    // command word, unused fields random
    task automatic send_control(input logic [2:0] k);
        send_word(k, 8'($urandom), 1'($urandom), 8'($urandom));
    endtask

    task automatic send_read(input logic [7:0] a);
        send_word(mrtu_pkg::KIND_READ, 8'($urandom), 1'($urandom), a);
    endtask

    task automatic send_ticks(input int n);
        int i;
        for (i = 0; i < n; i++)
        begin
            send_control(mrtu_pkg::KIND_TICK);
        end
    endtask

    // n random payload bytes plus crc, low byte first; optional single bit error,
    // the odd line-error byte mixed in
    task automatic send_frame(input int n, input logic corrupt);
        logic [15:0] c;
        logic [7:0]  b;
        int          bad;
        int          i;
        c   = mrtu_pkg::CRC_PRESET;
        bad = corrupt ? $urandom_range(n + 1) : -1;
        for (i = 0; i < n + 2; i++)
        begin
            if (i < n)
            begin
                b = 8'($urandom);
                c = modbus_crc_step(c, b);
            end
            else if (i == n)
            begin
                b = c[7:0];
            end
            else
            begin
                b = c[15:8];
            end
            if (i == bad)
            begin
                b = b ^ (8'h01 << $urandom_range(7));
            end
            if ($urandom_range(11) == 0)
            begin
                send_word(mrtu_pkg::KIND_BYTE, 8'($urandom), 1'b1, 8'($urandom));
            end
            send_word(mrtu_pkg::KIND_BYTE, b, 1'b0, 8'($urandom));
        end
    endtask

    // stop offering and let every pending result drain
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (framer_status_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (3) @(posedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [15:0] v);
        wait_for_results();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == mrtu_pkg::REG_SILENCE)
        begin
            gap_len = v;
        end
        else
        begin
            wait_len = v;
        end
    endtask

    task automatic test_directed();
        write_register(mrtu_pkg::REG_SILENCE, 16'd2);
        write_register(mrtu_pkg::REG_RESPONSE, 16'd2);
        // spare kinds leave the state alone
        send_control(KIND_SPARE6);
        send_control(KIND_SPARE7);
        // bytes after reset arrive in transmit mode and are still stored
        send_word(mrtu_pkg::KIND_BYTE, 8'h00, 1'b0, 8'hFF);
        send_word(mrtu_pkg::KIND_BYTE, 8'hFF, 1'b1, 8'h00);
        send_word(mrtu_pkg::KIND_BYTE, 8'hFF, 1'b0, 8'h00);
        send_read(8'd0);
        send_read(8'd1);
        send_ticks(2);
        // good frame: zero residue turns the driver to transmit
        send_control(mrtu_pkg::KIND_START_RX);
        send_frame(2, 1'b0);
        send_ticks(2);
        send_read(8'd3);
        // silence runs out and cancels the response wait on the same tick
        send_control(mrtu_pkg::KIND_TX_DONE);
        send_control(mrtu_pkg::KIND_RESP);
        send_ticks(2);
        // response timeout with no silence running
        send_control(mrtu_pkg::KIND_RESP);
        send_ticks(2);
        // empty frame at expiry in receive mode
        send_control(mrtu_pkg::KIND_TX_DONE);
        send_control(mrtu_pkg::KIND_START_RX);
        send_ticks(2);
        // lone byte and a corrupted frame both fail the crc
        send_word(mrtu_pkg::KIND_BYTE, 8'h55, 1'b0, 8'h80);
        send_ticks(2);
        send_frame(3, 1'b1);
        send_ticks(2);
        // shortest response wait
        write_register(mrtu_pkg::REG_RESPONSE, 16'd1);
        send_control(mrtu_pkg::KIND_RESP);
        send_control(mrtu_pkg::KIND_TICK);
    endtask

    // more bytes than the buffer holds, then reads at the top and in the middle
    task automatic test_buffer_full();
        send_control(mrtu_pkg::KIND_START_RX);
        send_frame(FRAME_BYTES, 1'b0);
        send_word(mrtu_pkg::KIND_BYTE, 8'hA5, 1'b1, 8'h00);
        send_read(8'd254);
        send_read(8'd127);
        send_read(8'd128);
        send_ticks(int'(gap_len));
    endtask

    // long receiver hold-off while words keep coming
    task automatic test_backpressure();
        int saved_gap;
        int i;
        saved_gap    = send_gap_pct;
        send_gap_pct = 0;
        hold_req <= hold_req + 1;
        for (i = 0; i < 40; i++)
        begin
            if (i % 3 == 0)
            begin
                send_control(mrtu_pkg::KIND_TICK);
            end
            else
            begin
                send_word(mrtu_pkg::KIND_BYTE, 8'($urandom), 1'b0, 8'($urandom));
            end
        end
        send_gap_pct = saved_gap;
    endtask

    // mostly well-formed exchanges, some corrupted, some plain noise
    task automatic test_random_traffic(input int n_words);
        int first;
        int pick;
        logic [2:0] k;
        write_register(mrtu_pkg::REG_SILENCE, 16'($urandom_range(5, 1)));
        write_register(mrtu_pkg::REG_RESPONSE, 16'($urandom_range(12, 1)));
        first = words_sent;
        while (words_sent - first < n_words)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
            begin
                // request frame, silence, then a look at the buffer
                if ($urandom_range(3) != 0)
                begin
                    send_control(mrtu_pkg::KIND_START_RX);
                end
                send_frame($urandom_range(6), $urandom_range(9) == 0);
                send_ticks(int'(gap_len) - 1 + $urandom_range(2));
                if (written_span > 0)
                begin
                    repeat ($urandom_range(3)) send_read(8'($urandom_range(written_span - 1)));
                end
            end
            else if (pick < 80)
            begin
                // reply sent, gap and response wait
                send_control(mrtu_pkg::KIND_TX_DONE);
                if ($urandom_range(1) == 0)
                begin
                    send_control(mrtu_pkg::KIND_RESP);
                end
                send_ticks($urandom_range(int'(gap_len) + int'(wait_len) + 1));
            end
            else
            begin
                k = 3'($urandom_range(5));
                if (k == mrtu_pkg::KIND_READ && written_span > 0)
                begin
                    send_read(8'($urandom_range(written_span - 1)));
                end
                else if (k == mrtu_pkg::KIND_READ)
                begin
                    send_control(mrtu_pkg::KIND_TICK);
                end
                else
                begin
                    send_word(k, 8'($urandom), $urandom_range(3) == 0, 8'($urandom));
                end
            end
        end
    endtask

    // largest register values, neither timer runs out within a short burst of ticks
    task automatic test_long_timers();
        write_register(mrtu_pkg::REG_SILENCE, 16'hFFFF);
        write_register(mrtu_pkg::REG_RESPONSE, 16'hFFFF);
        send_control(mrtu_pkg::KIND_TX_DONE);
        send_control(mrtu_pkg::KIND_RESP);
        send_ticks(40);
    endtask

    // one-byte frames failing the crc, each one counted
    task automatic test_error_count();
        int i;
        write_register(mrtu_pkg::REG_SILENCE, 16'd1);
        write_register(mrtu_pkg::REG_RESPONSE, 16'd1);
        send_control(mrtu_pkg::KIND_START_RX);
        send_control(mrtu_pkg::KIND_RESP);
        for (i = 0; i < 50; i++)
        begin
            send_word(mrtu_pkg::KIND_BYTE, 8'($urandom), 1'b0, 8'($urandom));
            send_control(mrtu_pkg::KIND_TICK);
        end
    endtask

    initial
    begin
        fill_count   = 0;
        written_span = 0;
        crc_acc      = mrtu_pkg::CRC_PRESET;
        gap_count    = 0;
        gap_running  = 1'b0;
        wait_count   = 0;
        wait_running = 1'b0;
        timeout_hit  = 1'b0;
        busy_st      = 1'b0;
        err_st       = 1'b0;
        code_st      = mrtu_pkg::ERR_NONE;
        ready_st     = 1'b0;
        rx_mode      = 1'b0;
        tx_drive     = 1'b0;
        fail_total   = 16'h0000;
        gap_len      = mrtu_pkg::SILENCE_RESET;
        wait_len     = mrtu_pkg::RESPONSE_RESET;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_gap_pct = 33;
        recv_gap_pct = 49;
        test_directed();
        test_buffer_full();
        test_backpressure();
        test_random_traffic(180);

        send_gap_pct = 49;
        recv_gap_pct = 33;
        test_random_traffic(180);

        send_gap_pct = 0;
        recv_gap_pct = 0;
        test_random_traffic(180);
        test_long_timers();
        test_error_count();

        wait_for_results();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
